/* sv/cbsd_pkg.sv */
package cbsd_pkg;

    // Stream framing
    localparam int unsigned BLOCK_BYTES = 256;
    localparam int unsigned POS_W       = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_BYTES - 1);

    // Key generator constants
    localparam logic [15:0] KEY_SEED_RESET = 16'h2711;
    localparam logic [15:0] KEY_MUL        = 16'h0055;
    localparam logic [7:0]  KEY_LO_MUL     = 8'h62;
    localparam logic [15:0] KEY_ADD        = 16'h3619;

    // CRC-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

    // Configuration port
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [0:0]  REG_KEY_SEED = 1'b0;

    // One result word
    typedef struct packed {
        logic [7:0]  plain_byte;
        logic [31:0] crc_so_far;
    } res_t;

    // Advance the key generator by one multiply-add step
    function automatic logic [15:0] key_advance(input logic [15:0] key);
        logic [15:0] prod;
        logic [7:0]  lo_term;
        prod    = 16'(key * KEY_MUL);
        lo_term = 8'(key[7:0] * KEY_LO_MUL);
        return 16'(prod + {lo_term, 8'h00} + KEY_ADD);
    endfunction

    // Fold one byte into the CRC, bit by bit, least significant first
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'h000000, data};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0000_0000);
        end
        return c;
    endfunction

endpackage

/* sv/cbsd_in_if.sv */
interface cbsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       restart;

    modport source (output valid, output cipher_byte, output restart, input ready);
    modport sink   (input valid, input cipher_byte, input restart, output ready);
endinterface

/* sv/cbsd_out_if.sv */
interface cbsd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  plain_byte;
    logic [31:0] crc_so_far;

    modport source (output valid, output plain_byte, output crc_so_far, input ready);
    modport sink   (input valid, input plain_byte, input crc_so_far, output ready);
endinterface

/* sv/chained_block_stream_decrypt_crc.sv */
// Chained block stream decryptor with running CRC-32. Each word on the stream
// port carries one cipher byte and a restart flag; each word on the result
// port carries the plain byte and the complemented CRC-32 over all plain
// bytes since the last restart, this one included. One byte is taken every
// clock cycle while the output buffer has space: the key generator, chain
// byte, block position and CRC are updated together as the byte is taken,
// and that state loop sets the rate. Each result is registered in the
// output buffer before it appears on the port. A two-word output buffer lets
// the stream keep flowing while a result waits; the stream stalls only once
// both words are full. The key seed register (byte address 0) is loaded into
// the key generator at each restart; write it only while the block is idle.
module chained_block_stream_decrypt_crc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbsd_pkg::APB_AW-1:0]      paddr,
    input  logic [cbsd_pkg::APB_DW-1:0]      pwdata,
    output logic [cbsd_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    cbsd_in_if.sink                          stream,
    cbsd_out_if.source                       result
);

    logic [15:0]    key_seed;
    logic           space;
    logic           res_valid;
    cbsd_pkg::res_t res;

    // Configuration registers
    cbsd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .key_seed (key_seed)
    );

    // Decrypt and CRC state
    cbsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .key_seed  (key_seed),
        .space     (space),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register with skid stage
    cbsd_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .result    (result)
    );

endmodule

/* sv/cbsd_cfg.sv */
module cbsd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbsd_pkg::APB_AW-1:0]      paddr,
    input  logic [cbsd_pkg::APB_DW-1:0]      pwdata,
    output logic [cbsd_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    output logic [15:0]                      key_seed
);

    logic [15:0] key_seed_reg;
    logic [15:0] key_seed_next;
    logic        wr_en;
    logic        sel_seed;

    assign pready   = 1'b1;
    assign sel_seed = (paddr[cbsd_pkg::APB_AW-1:2] == cbsd_pkg::REG_KEY_SEED);
    assign wr_en    = psel & penable & pwrite & pready;

    // Take the new seed on a completed write to its word
    always_comb
    begin
        key_seed_next = key_seed_reg;
        if (wr_en && sel_seed)
        begin
            key_seed_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_seed_reg <= cbsd_pkg::KEY_SEED_RESET;
        end
        else
        begin
            key_seed_reg <= key_seed_next;
        end
    end

    // Read back the seed, zero elsewhere
    always_comb
    begin
        prdata = '0;
        if (sel_seed)
        begin
            prdata = {{(cbsd_pkg::APB_DW-16){1'b0}}, key_seed_reg};
        end
    end

    assign key_seed = key_seed_reg;

endmodule

/* sv/cbsd_core.sv */
module cbsd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    cbsd_in_if.sink              stream,
    input  logic [15:0]          key_seed,
    input  logic                 space,
    output logic                 res_valid,
    output cbsd_pkg::res_t       res
);

    logic [15:0]                   key_reg,   key_next;
    logic [7:0]                    chain_reg, chain_next;
    logic [cbsd_pkg::POS_W-1:0]    pos_reg,   pos_next;
    logic [31:0]                   crc_reg,   crc_next;

    logic [15:0]                   key_base;
    logic [7:0]                    chain_base;
    logic [cbsd_pkg::POS_W-1:0]    pos_base;
    logic [31:0]                   crc_base;
    logic                          at_start;
    logic [15:0]                   key_step;
    logic [7:0]                    chain_use;
    logic [7:0]                    plain;
    logic [31:0]                   crc_step;
    logic [cbsd_pkg::POS_W-1:0]    pos_step;
    logic                          accept;

    assign stream.ready = space;
    assign accept       = stream.valid & space;

    // Restart reloads the seed and clears position, chain and CRC first
    always_comb
    begin
        key_base   = stream.restart ? key_seed : key_reg;
        chain_base = stream.restart ? 8'h00 : chain_reg;
        pos_base   = stream.restart ? '0 : pos_reg;
        crc_base   = stream.restart ? cbsd_pkg::CRC_INIT : crc_reg;
    end

    // Advance the key at a block start, decrypt and fold into the CRC
    always_comb
    begin
        at_start  = (pos_base == '0);
        key_step  = at_start ? cbsd_pkg::key_advance(key_base) : key_base;
        chain_use = at_start ? key_step[15:8] : chain_base;
        plain     = stream.cipher_byte ^ chain_use;
        crc_step  = cbsd_pkg::crc_fold(crc_base, plain);
        pos_step  = (pos_base == cbsd_pkg::POS_LAST) ? '0 : pos_base + 1'b1;
    end

    // Commit the state only when a word is taken
    always_comb
    begin
        key_next   = key_reg;
        chain_next = chain_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        if (accept)
        begin
            key_next   = key_step;
            chain_next = plain;
            pos_next   = pos_step;
            crc_next   = crc_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= cbsd_pkg::KEY_SEED_RESET;
            chain_reg <= 8'h00;
            pos_reg   <= '0;
            crc_reg   <= cbsd_pkg::CRC_INIT;
        end
        else
        begin
            key_reg   <= key_next;
            chain_reg <= chain_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
        end
    end

    assign res_valid      = accept;
    assign res.plain_byte = plain;
    assign res.crc_so_far = ~crc_step;

endmodule

/* sv/cbsd_obuf.sv */
module cbsd_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  cbsd_pkg::res_t       res,
    output logic                 space,
    cbsd_out_if.source           result
);

    logic           main_valid_reg, main_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    cbsd_pkg::res_t main_reg,       main_next;
    cbsd_pkg::res_t skid_reg,       skid_next;
    logic           pop;

    assign space = ~skid_valid_reg;
    assign pop   = main_valid_reg & result.ready;

    // Drain the skid stage first, else load the new word into main or skid
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result.valid      = main_valid_reg;
    assign result.plain_byte = main_reg.plain_byte;
    assign result.crc_so_far = main_reg.crc_so_far;

endmodule
